@@ src/matrix_multiply_top_defines.svh @@
// Assertion macros for the matrix multiply block.
// Used by matrix_multiply_top; expects i_clk and i_rst_n in scope.
`ifndef MATRIX_MULTIPLY_TOP_DEFINES_SVH
`define MATRIX_MULTIPLY_TOP_DEFINES_SVH

// same-cycle implication
`define MM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/mm_pkg.sv @@
// Shared types, codes and helpers for the matrix multiply block.
// No dependencies.
`timescale 1ns / 1ps

package mm_pkg;

    localparam int MAX_DIM_DEF    = 8;
    localparam int ELEM_WIDTH_DEF = 32;
    localparam int IDX_W          = 3;
    localparam int VAL_W          = 32;
    localparam int DIM_W          = 4;
    localparam int ACT_W          = 2;
    localparam int CFG_IDX_W      = 2;

    localparam logic [ACT_W-1:0] ACT_WR_A    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WR_B    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]        out_row;
        logic [IDX_W-1:0]        out_col;
        logic signed [VAL_W-1:0] out_value;
        logic                    saturated;
        logic                    last;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [DIM_W-1:0]     wdata;
    } t_cfg_item;

    // travels with each MAC step
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             lastk;
        logic             lastel;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
    } t_tag;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mac_stat;

    // last loop index for a dimension register: 0 acts as 1, above max acts as max
    function automatic logic [IDX_W-1:0] dim_last(input logic [DIM_W-1:0] v,
                                                  input int unsigned max_dim);
        if (v == '0) begin
            return '0;
        end else if (int'(v) > max_dim) begin
            return IDX_W'(max_dim - 1);
        end else begin
            return IDX_W'(v - DIM_W'(1));
        end
    endfunction

endpackage

@@ src/mm_intf.sv @@
// Handshake channels of the matrix multiply block: input, result, config.
// Depends on mm_pkg.
`timescale 1ns / 1ps

interface mm_in_if;
    logic             valid;
    logic             ready;
    mm_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mm_out_if;
    logic              valid;
    logic              ready;
    mm_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mm_cfg_if;
    logic              valid;
    logic              ready;
    mm_pkg::t_cfg_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ src/mm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module mm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/mm_mac.sv @@
// Multiply-accumulate pipe: product register, accumulator, round and saturate.
// Depends on mm_pkg.
`timescale 1ns / 1ps

module mm_mac #(
    parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
    parameter int ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_stall,
    input  mm_pkg::t_tag           i_tag,
    input  logic [ELEM_WIDTH-1:0]  i_a,
    input  logic [ELEM_WIDTH-1:0]  i_b,
    output mm_pkg::t_mac_stat      o_stat,
    output mm_pkg::t_out_item      o_item
);

    localparam int EW    = ELEM_WIDTH;
    localparam int FRAC  = EW / 2;
    localparam int PW    = 2 * EW;
    localparam int ACC_W = PW + $clog2(MAX_DIM) + 1;
    localparam int VW    = mm_pkg::VAL_W;

    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC - 1);
    localparam logic signed [ACC_W-1:0] MAXV = (ACC_W'(1) << (EW - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] MINV = -(ACC_W'(1) << (EW - 1));

    mm_pkg::t_tag             r_s2;
    mm_pkg::t_tag             r_s3;
    logic signed [PW-1:0]     r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    logic signed [EW-1:0]     a_s;
    logic signed [EW-1:0]     b_s;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [ACC_W-1:0]  shr;
    logic signed [EW-1:0]     res;
    logic                     clip;

    assign a_s      = i_a;
    assign b_s      = i_b;
    assign prod_ext = ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
        end else if (!i_stall) begin
            r_s2 <= i_tag;
            r_s3 <= r_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_stall) begin
            r_prod <= a_s * b_s;
            if (r_s2.valid) begin
                r_acc <= r_s2.first ? prod_ext : r_acc + prod_ext;
            end
        end
    end

    // round to nearest, ties up, then clip to the element range
    always_comb begin
        rnd  = r_acc + HALF;
        shr  = rnd >>> FRAC;
        clip = 1'b0;
        res  = shr[EW-1:0];
        if (shr > MAXV) begin
            res  = MAXV[EW-1:0];
            clip = 1'b1;
        end else if (shr < MINV) begin
            res  = MINV[EW-1:0];
            clip = 1'b1;
        end
    end

    assign o_stat.busy       = r_s2.valid || r_s3.valid;
    assign o_stat.done       = r_s3.valid && r_s3.lastk;
    assign o_item.out_row    = r_s3.i;
    assign o_item.out_col    = r_s3.j;
    assign o_item.out_value  = VW'(res);
    assign o_item.saturated  = clip;
    assign o_item.last       = r_s3.lastel;

endmodule

@@ src/matrix_multiply_top.sv @@
// Matrix multiply top level: sequencer, A and B stores, MAC pipe, result register.
// Depends on mm_pkg, mm_intf, mm_ram, mm_mac and matrix_multiply_top_defines.svh.
//
//   port    dir  content
//   i_in    in   action, row, col, value (load A, load B, compute)
//   i_cfg   in   reg_idx, wdata (rows_a, inner_dim, cols_b)
//   o_out   out  out_row, out_col, out_value, saturated, last
//
// A load is written to its store when accepted. A compute item runs
// rows*cols*inner MAC steps, one per cycle unless the output stalls, bound by
// the single read port of each store. Reset is synchronous; the stores are not
// cleared. A result waiting in the output register freezes the whole pipe;
// new input is taken once the pipe has drained, even while the last result waits.
`timescale 1ns / 1ps

`include "matrix_multiply_top_defines.svh"

module matrix_multiply_top #(
    parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
    parameter int ELEM_WIDTH = mm_pkg::ELEM_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mm_in_if.sink     i_in,
    mm_cfg_if.sink    i_cfg,
    mm_out_if.source  o_out
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int IW    = mm_pkg::IDX_W;
    localparam int DW    = mm_pkg::DIM_W;

    logic [DW-1:0]          r_rows_a;
    logic [DW-1:0]          r_inner_dim;
    logic [DW-1:0]          r_cols_b;
    mm_pkg::t_state         r_state;
    mm_pkg::t_state         n_state;
    logic [IW-1:0]          r_i;
    logic [IW-1:0]          r_j;
    logic [IW-1:0]          r_k;
    logic [IW-1:0]          r_last_i;
    logic [IW-1:0]          r_last_j;
    logic [IW-1:0]          r_last_k;
    mm_pkg::t_tag           r_s1;
    mm_pkg::t_tag           n_tag;
    logic                   r_ov;
    mm_pkg::t_out_item      r_out;

    logic                   in_acc;
    logic                   start;
    logic                   wr_ok;
    logic                   we_a;
    logic                   we_b;
    logic [AW-1:0]          waddr;
    logic [AW-1:0]          raddr_a;
    logic [AW-1:0]          raddr_b;
    logic                   issue;
    logic                   at_end;
    logic                   stall;
    logic [ELEM_WIDTH-1:0]  rd_a;
    logic [ELEM_WIDTH-1:0]  rd_b;
    mm_pkg::t_mac_stat      mac_stat;
    mm_pkg::t_out_item      mac_item;

    // config port
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= DW'(8);
            r_inner_dim <= DW'(8);
            r_cols_b    <= DW'(8);
        end else if (i_cfg.valid) begin
            case (i_cfg.payload.reg_idx)
                mm_pkg::CFG_ROWS_A:    r_rows_a    <= i_cfg.payload.wdata;
                mm_pkg::CFG_INNER_DIM: r_inner_dim <= i_cfg.payload.wdata;
                mm_pkg::CFG_COLS_B:    r_cols_b    <= i_cfg.payload.wdata;
                default: ;
            endcase
        end
    end

    // input side
    assign i_in.ready = (r_state == mm_pkg::ST_IDLE) && !r_s1.valid && !mac_stat.busy;
    assign in_acc     = i_in.valid && i_in.ready;
    assign start      = in_acc && (i_in.payload.action == mm_pkg::ACT_COMPUTE);
    assign wr_ok      = ({1'b0, i_in.payload.row} < 4'(MAX_DIM))
                     && ({1'b0, i_in.payload.col} < 4'(MAX_DIM));
    assign we_a       = in_acc && wr_ok && (i_in.payload.action == mm_pkg::ACT_WR_A);
    assign we_b       = in_acc && wr_ok && (i_in.payload.action == mm_pkg::ACT_WR_B);
    assign waddr      = AW'(i_in.payload.row) * AW'(MAX_DIM) + AW'(i_in.payload.col);

    // sequencer
    assign stall   = r_ov && !o_out.ready;
    assign at_end  = (r_i == r_last_i) && (r_j == r_last_j) && (r_k == r_last_k);
    assign raddr_a = AW'(r_i) * AW'(MAX_DIM) + AW'(r_k);
    assign raddr_b = AW'(r_k) * AW'(MAX_DIM) + AW'(r_j);

    always_comb begin
        n_state = r_state;
        case (r_state)
            mm_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = mm_pkg::ST_RUN;
                end
            end
            mm_pkg::ST_RUN: begin
                if (!stall && at_end) begin
                    n_state = mm_pkg::ST_IDLE;
                end
            end
            default: n_state = mm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        issue        = (r_state == mm_pkg::ST_RUN) && !stall;
        n_tag.valid  = issue;
        n_tag.first  = (r_k == '0);
        n_tag.lastk  = (r_k == r_last_k);
        n_tag.lastel = at_end;
        n_tag.i      = r_i;
        n_tag.j      = r_j;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_last_i <= mm_pkg::dim_last(r_rows_a, MAX_DIM);
            r_last_j <= mm_pkg::dim_last(r_cols_b, MAX_DIM);
            r_last_k <= mm_pkg::dim_last(r_inner_dim, MAX_DIM);
        end else if (issue) begin
            if (r_k == r_last_k) begin
                r_k <= '0;
                if (r_j == r_last_j) begin
                    r_j <= '0;
                    r_i <= r_i + IW'(1);
                end else begin
                    r_j <= r_j + IW'(1);
                end
            end else begin
                r_k <= r_k + IW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (!stall) begin
            r_s1 <= n_tag;
        end
    end

    mm_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (waddr),
        .i_wdata (i_in.payload.value[ELEM_WIDTH-1:0]),
        .i_re    (issue),
        .i_raddr (raddr_a),
        .o_rdata (rd_a)
    );

    mm_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (waddr),
        .i_wdata (i_in.payload.value[ELEM_WIDTH-1:0]),
        .i_re    (issue),
        .i_raddr (raddr_b),
        .o_rdata (rd_b)
    );

    mm_mac #(
        .MAX_DIM    (MAX_DIM),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stall (stall),
        .i_tag   (r_s1),
        .i_a     (rd_a),
        .i_b     (rd_b),
        .o_stat  (mac_stat),
        .o_item  (mac_item)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (!stall && mac_stat.done) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!stall && mac_stat.done) begin
            r_out <= mac_item;
        end
    end

    assign o_out.valid   = r_ov;
    assign o_out.payload = r_out;

    `MM_ASSERT_NEXT(a_start_runs, start, r_state == mm_pkg::ST_RUN, "compute did not start")
    `MM_ASSERT_NOW(a_last_after_issue, mac_stat.done && mac_item.last, r_state == mm_pkg::ST_IDLE, "final element while still issuing")
    `MM_ASSERT_NEXT(a_stall_holds_run, (r_state == mm_pkg::ST_RUN) && stall, r_state == mm_pkg::ST_RUN, "sequencer left run while stalled")

endmodule
